/* rtl/core/grpm_pkg.sv */
package grpm_pkg;

    localparam int COEF_W        = 12;
    localparam int PROD_W        = 2 * COEF_W;
    localparam int DEGREE_DEF    = 4;
    localparam int BARRETT_SHIFT = 24;

    localparam logic [COEF_W-1:0] MODULUS   = 12'd3329;
    localparam logic [12:0]       BARRETT_M = 13'd5039;

    typedef logic [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t a_real;
        coef_t a_phi;
        coef_t b_real;
        coef_t b_phi;
    } coef_tuple_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } mac_ctl_t;

    typedef struct packed {
        logic wr_en;
        logic acc_clear;
        logic emit;
        logic last;
    } seq_ctl_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_CALC,
        S_DRAIN
    } state_t;

    function automatic coef_t mod_add(coef_t x, coef_t y);
        logic [COEF_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, MODULUS})
        begin
            return COEF_W'(s - {1'b0, MODULUS});
        end
        return s[COEF_W-1:0];
    endfunction

    function automatic coef_t mod_sub(coef_t x, coef_t y);
        logic [COEF_W:0] s;
        s = {1'b0, x} + {1'b0, MODULUS} - {1'b0, y};
        if (x >= y)
        begin
            return x - y;
        end
        return s[COEF_W-1:0];
    endfunction

endpackage

/* rtl/core/grpm_store.sv */
module grpm_store #(
    parameter int DEGREE = grpm_pkg::DEGREE_DEF,
    localparam int IDX_W = $clog2(DEGREE)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_addr,
    input  grpm_pkg::coef_tuple_t  wr_data,
    input  grpm_pkg::mac_ctl_t     rd_ctl,
    input  logic [IDX_W-1:0]       rd_x_addr,
    input  logic [IDX_W-1:0]       rd_y_addr,
    output grpm_pkg::mac_ctl_t     q_ctl,
    output grpm_pkg::coef_tuple_t  q_data
);
    import grpm_pkg::*;

    function automatic coef_t reduce(coef_t v);
        return (v >= MODULUS) ? coef_t'(v - MODULUS) : v;
    endfunction

    logic [2*COEF_W-1:0] mem_x [DEGREE];
    logic [2*COEF_W-1:0] mem_y [DEGREE];
    logic [2*COEF_W-1:0] x_q_reg;
    logic [2*COEF_W-1:0] y_q_reg;
    mac_ctl_t            q_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= {reduce(wr_data.a_real), reduce(wr_data.a_phi)};
            mem_y[wr_addr] <= {reduce(wr_data.b_real), reduce(wr_data.b_phi)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_ctl.valid)
        begin
            x_q_reg <= mem_x[rd_x_addr];
            y_q_reg <= mem_y[rd_y_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_ctl_reg <= '0;
        end
        else
        begin
            q_ctl_reg <= rd_ctl;
        end
    end

    assign q_ctl         = q_ctl_reg;
    assign q_data.a_real = x_q_reg[2*COEF_W-1:COEF_W];
    assign q_data.a_phi  = x_q_reg[COEF_W-1:0];
    assign q_data.b_real = y_q_reg[2*COEF_W-1:COEF_W];
    assign q_data.b_phi  = y_q_reg[COEF_W-1:0];

endmodule

/* rtl/core/grpm_lane.sv */
module grpm_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  grpm_pkg::mac_ctl_t in_ctl,
    input  grpm_pkg::coef_t    x,
    input  grpm_pkg::coef_t    y,
    output logic               busy,
    output grpm_pkg::coef_t    acc
);
    import grpm_pkg::*;

    localparam int T_W = BARRETT_SHIFT + COEF_W;

    mac_ctl_t          s1_ctl_reg;
    mac_ctl_t          s2_ctl_reg;
    mac_ctl_t          s3_ctl_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod2_reg;
    coef_t             quot_reg;
    coef_t             rem_reg;
    coef_t             rem_next;
    coef_t             acc_reg;
    coef_t             acc_next;
    logic [T_W-1:0]    quot_prod;
    logic [PROD_W-1:0] rem_wide;

    always_comb
    begin
        quot_prod = T_W'(prod_reg) * T_W'(BARRETT_M);
        rem_wide  = prod2_reg - PROD_W'(quot_reg) * PROD_W'(MODULUS);
        if (rem_wide >= PROD_W'(MODULUS))
        begin
            rem_next = COEF_W'(rem_wide - PROD_W'(MODULUS));
        end
        else
        begin
            rem_next = rem_wide[COEF_W-1:0];
        end
        acc_next = acc_reg;
        if (clear)
        begin
            acc_next = '0;
        end
        else if (s3_ctl_reg.valid)
        begin
            acc_next = s3_ctl_reg.neg ? mod_sub(acc_reg, rem_reg) : mod_add(acc_reg, rem_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
        end
        else
        begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= PROD_W'(x) * PROD_W'(y);
        prod2_reg <= prod_reg;
        quot_reg  <= quot_prod[BARRETT_SHIFT +: COEF_W];
        rem_reg   <= rem_next;
        acc_reg   <= acc_next;
    end

    assign busy = s1_ctl_reg.valid | s2_ctl_reg.valid | s3_ctl_reg.valid;
    assign acc  = acc_reg;

endmodule

/* rtl/core/grpm_seq.sv */
module grpm_seq #(
    parameter int DEGREE = grpm_pkg::DEGREE_DEF,
    localparam int IDX_W = $clog2(DEGREE)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               busy,
    input  logic               slot_free,
    output grpm_pkg::seq_ctl_t ctl,
    output grpm_pkg::mac_ctl_t issue,
    output logic [IDX_W-1:0]   load_addr,
    output logic [IDX_W-1:0]   rd_x_addr,
    output logic [IDX_W-1:0]   rd_y_addr
);
    import grpm_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEGREE - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] load_reg;
    logic [IDX_W-1:0] load_next;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] i_next;
    logic [IDX_W:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            load_reg  <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            load_reg  <= load_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        load_next   = load_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        in_ready    = 1'b0;
        ctl         = '0;
        issue.valid = 1'b0;
        issue.neg   = i_reg > k_reg;
        diff        = {1'b0, k_reg} - {1'b0, i_reg};
        if (issue.neg)
        begin
            diff = diff + (IDX_W+1)'(DEGREE);
        end
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.wr_en = 1'b1;
                    if (load_reg == LAST)
                    begin
                        load_next     = '0;
                        k_next        = '0;
                        i_next        = '0;
                        ctl.acc_clear = 1'b1;
                        state_next    = S_CALC;
                    end
                    else
                    begin
                        load_next = load_reg + 1'b1;
                    end
                end
            end
            S_CALC:
            begin
                issue.valid = 1'b1;
                if (i_reg == LAST)
                begin
                    i_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (!busy && slot_free)
                begin
                    ctl.emit      = 1'b1;
                    ctl.acc_clear = 1'b1;
                    ctl.last      = k_reg == LAST;
                    if (k_reg == LAST)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_CALC;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign load_addr = load_reg;
    assign rd_x_addr = i_reg;
    assign rd_y_addr = diff[IDX_W-1:0];

endmodule

/* rtl/core/golden_ring_poly_multiplier_core.sv */
// Channel | Handshake             | Payload
// input   | in_valid / in_ready   | a_real, a_phi, b_real, b_phi
// output  | out_valid / out_ready | prod_real, prod_phi, coef_last
//
// Loading writes one coefficient tuple per accepted transfer; the last tuple starts the product.
// Each result coefficient then needs DEGREE reads of the coefficient memories, fed
// through four shared multiply-reduce lanes, then the pipeline drain.
// A full product needs DEGREE loads and yields DEGREE result coefficients.
// Reset clears the sequencer state, its indices and the output valid flag; memory and output data are not cleared.
// A stalled output holds one coefficient and stops the sequencer before the next emit.
module golden_ring_poly_multiplier_core #(
    parameter int DEGREE = grpm_pkg::DEGREE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  grpm_pkg::coef_t a_real,
    input  grpm_pkg::coef_t a_phi,
    input  grpm_pkg::coef_t b_real,
    input  grpm_pkg::coef_t b_phi,
    output logic            out_valid,
    input  logic            out_ready,
    output grpm_pkg::coef_t prod_real,
    output grpm_pkg::coef_t prod_phi,
    output logic            coef_last
);
    import grpm_pkg::*;

    localparam int IDX_W = $clog2(DEGREE);

    seq_ctl_t         ctl;
    mac_ctl_t         issue;
    mac_ctl_t         q_ctl;
    coef_tuple_t      wr_data;
    coef_tuple_t      q_data;
    logic [IDX_W-1:0] load_addr;
    logic [IDX_W-1:0] rd_x_addr;
    logic [IDX_W-1:0] rd_y_addr;
    logic             busy_ac;
    logic             busy_bd;
    logic             busy_ad;
    logic             busy_bc;
    logic             busy;
    logic             slot_free;
    coef_t            acc_ac;
    coef_t            acc_bd;
    coef_t            acc_ad;
    coef_t            acc_bc;
    logic             out_valid_reg;
    coef_t            prod_real_reg;
    coef_t            prod_phi_reg;
    logic             coef_last_reg;

    assign wr_data.a_real = a_real;
    assign wr_data.a_phi  = a_phi;
    assign wr_data.b_real = b_real;
    assign wr_data.b_phi  = b_phi;

    assign busy      = q_ctl.valid | busy_ac | busy_bd | busy_ad | busy_bc;
    assign slot_free = !out_valid_reg || out_ready;

    grpm_seq #(.DEGREE(DEGREE)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .busy      (busy),
        .slot_free (slot_free),
        .ctl       (ctl),
        .issue     (issue),
        .load_addr (load_addr),
        .rd_x_addr (rd_x_addr),
        .rd_y_addr (rd_y_addr)
    );

    grpm_store #(.DEGREE(DEGREE)) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (ctl.wr_en),
        .wr_addr   (load_addr),
        .wr_data   (wr_data),
        .rd_ctl    (issue),
        .rd_x_addr (rd_x_addr),
        .rd_y_addr (rd_y_addr),
        .q_ctl     (q_ctl),
        .q_data    (q_data)
    );

    grpm_lane u_lane_ac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (ctl.acc_clear),
        .in_ctl (q_ctl),
        .x      (q_data.a_real),
        .y      (q_data.b_real),
        .busy   (busy_ac),
        .acc    (acc_ac)
    );

    grpm_lane u_lane_bd (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (ctl.acc_clear),
        .in_ctl (q_ctl),
        .x      (q_data.a_phi),
        .y      (q_data.b_phi),
        .busy   (busy_bd),
        .acc    (acc_bd)
    );

    grpm_lane u_lane_ad (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (ctl.acc_clear),
        .in_ctl (q_ctl),
        .x      (q_data.a_real),
        .y      (q_data.b_phi),
        .busy   (busy_ad),
        .acc    (acc_ad)
    );

    grpm_lane u_lane_bc (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (ctl.acc_clear),
        .in_ctl (q_ctl),
        .x      (q_data.a_phi),
        .y      (q_data.b_real),
        .busy   (busy_bc),
        .acc    (acc_bc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            prod_real_reg <= mod_add(acc_ac, acc_bd);
            prod_phi_reg  <= mod_add(mod_add(acc_ad, acc_bc), acc_bd);
            coef_last_reg <= ctl.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign prod_real = prod_real_reg;
    assign prod_phi  = prod_phi_reg;
    assign coef_last = coef_last_reg;

endmodule

/* rtl/core/grpm_checker.sv */
module grpm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input grpm_pkg::coef_t a_real,
    input grpm_pkg::coef_t a_phi,
    input grpm_pkg::coef_t b_real,
    input grpm_pkg::coef_t b_phi,
    input logic            out_valid,
    input logic            out_ready,
    input grpm_pkg::coef_t prod_real,
    input grpm_pkg::coef_t prod_phi,
    input logic            coef_last
);
    import grpm_pkg::*;

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prod_real)
            && $stable(prod_phi) && $stable(coef_last))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> prod_real < MODULUS && prod_phi < MODULUS)
        else $error("result coefficient not reduced");

    // loading stays closed until the last coefficient is out
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !coef_last |-> !in_ready)
        else $error("input open during product");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("input closed without transfer");

    // hold a waiting input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(a_real) && $stable(a_phi)
            && $stable(b_real) && $stable(b_phi))
        else $error("waiting input changed");

endmodule

bind golden_ring_poly_multiplier_core grpm_checker u_grpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .a_real    (a_real),
    .a_phi     (a_phi),
    .b_real    (b_real),
    .b_phi     (b_phi),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .prod_real (prod_real),
    .prod_phi  (prod_phi),
    .coef_last (coef_last)
);
